@@ design/ntbr_pkg.sv @@
// shared types and constants for the neighbor table with best-rssi selection
`timescale 1ns / 1ps
package ntbr_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_W        = 16;
  localparam int STR_W         = 16;
  localparam int OUTCOME_W     = 2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_UPDATED = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_ADDED   = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED = 2'd2;

  // lookup record that walks the row of cells, one cell per cycle
  typedef struct packed {
    logic              active;
    logic [ADDR_W-1:0] addr;
    logic [STR_W-1:0]  strength;
    logic              hit;
    logic              added;
    logic              best_valid;
    logic [ADDR_W-1:0] best_addr;
    logic [STR_W-1:0]  best_strength;
  } probe_t;

endpackage

@@ design/ntbr_cell.sv @@
// one table slot: address match, insert into first free slot, running maximum
`timescale 1ns / 1ps
module ntbr_cell (
  input  logic            clk,
  input  logic            rst,
  input  ntbr_pkg::probe_t probe_in,
  output ntbr_pkg::probe_t probe_out
);
  import ntbr_pkg::*;

  logic              used;
  logic [ADDR_W-1:0] addr;
  logic [STR_W-1:0]  strength;

  logic              done;
  logic              match;
  logic              take;
  logic              cur_used;
  logic [ADDR_W-1:0] cur_addr;
  logic [STR_W-1:0]  cur_str;
  logic              better;
  probe_t            probe_next;

  assign done     = probe_in.hit | probe_in.added;
  assign match    = used && (addr == probe_in.addr) && !done;
  // slots fill in order, so the first unused one seen is the free slot
  assign take     = !used && !done;
  assign cur_used = used | take;
  assign cur_addr = take ? probe_in.addr : addr;
  assign cur_str  = (match || take) ? probe_in.strength : strength;
  // ties go to the later slot
  assign better   = cur_used && (!probe_in.best_valid || (cur_str >= probe_in.best_strength));

  always_comb begin
    probe_next = probe_in;
    probe_next.hit = probe_in.hit | match;
    probe_next.added = probe_in.added | take;
    if (better) begin
      probe_next.best_valid    = 1'b1;
      probe_next.best_addr     = cur_addr;
      probe_next.best_strength = cur_str;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (probe_in.active && take) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (probe_in.active && (match || take)) begin
      strength <= probe_in.strength;
    end
    if (probe_in.active && take) begin
      addr <= probe_in.addr;
    end
  end

  // record register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

@@ design/neighbor_table_best_rssi.sv @@
// top level: neighbor table with best-rssi selection built as a row of slot cells
`timescale 1ns / 1ps
// Each input transaction carries a sender address and a signal strength. The
// table is a row of TABLE_ENTRIES cells, one slot each; a lookup record enters
// cell 0 and moves one cell per clock. In every cell it updates the stored
// strength on an address match, or claims the slot if it is the first free one,
// and then folds that slot into a running maximum (ties favor the later slot).
// When the record leaves the last cell the result transaction (outcome, best
// address and strength) is held in an output register until taken. One item
// is in flight at a time: cell 0 registers the record at the accept edge, the
// record then passes through each cell register in turn, and out_valid is set
// by the output register once the record leaves the last cell. The next item
// is accepted in the cycle after the result is taken, so the block holds each
// item from accept until its result is taken, including any output stall. The
// table is empty after reset with no clearing pass; slots are never freed,
// and a new sender arriving while every slot is used is dropped.
module neighbor_table_best_rssi (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ntbr_pkg::ADDR_W-1:0] sender_addr,
  input  logic [ntbr_pkg::STR_W-1:0]  signal_strength,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ntbr_pkg::OUTCOME_W-1:0] outcome,
  output logic                      best_valid,
  output logic [ntbr_pkg::ADDR_W-1:0] best_addr,
  output logic [ntbr_pkg::STR_W-1:0]  best_strength
);
  import ntbr_pkg::*;

  // probe[i] enters cell i; probe[TABLE_ENTRIES] leaves the last cell
  probe_t probe [TABLE_ENTRIES+1];
  logic   busy;
  logic   in_fire;
  logic   out_fire;
  logic   done_fire;

  assign in_stall  = busy;
  assign in_fire   = in_valid && !busy;
  assign out_fire  = out_valid && !out_stall;
  assign done_fire = probe[TABLE_ENTRIES].active;

  // fresh record: nothing found yet, empty running maximum
  always_comb begin
    probe[0].active        = in_fire;
    probe[0].addr          = sender_addr;
    probe[0].strength      = signal_strength;
    probe[0].hit           = 1'b0;
    probe[0].added         = 1'b0;
    probe[0].best_valid    = 1'b0;
    probe[0].best_addr     = '0;
    probe[0].best_strength = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ntbr_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe_in (probe[i]),
      .probe_out(probe[i+1])
    );
  end

  // busy from accept until the result transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_fire) begin
      busy <= 1'b1;
    end else if (out_fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // result register, loaded when the record leaves the row
  always_ff @(posedge clk) begin
    if (done_fire) begin
      if (probe[TABLE_ENTRIES].hit) begin
        outcome <= OUTCOME_UPDATED;
      end else if (probe[TABLE_ENTRIES].added) begin
        outcome <= OUTCOME_ADDED;
      end else begin
        outcome <= OUTCOME_DROPPED;
      end
      best_valid    <= probe[TABLE_ENTRIES].best_valid;
      best_addr     <= probe[TABLE_ENTRIES].best_addr;
      best_strength <= probe[TABLE_ENTRIES].best_strength;
    end
  end

endmodule

@@ tb/neighbor_table_best_rssi_tb.sv @@
// testbench for the neighbor table with best-rssi selection
`timescale 1ns / 1ps
module neighbor_table_best_rssi_tb;
  import ntbr_pkg::*;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [STR_W-1:0]  str_t;

  // one expected result transaction
  typedef struct {
    logic [OUTCOME_W-1:0] outcome;
    logic                 best_valid;
    addr_t                best_addr;
    str_t                 best_strength;
  } link_report_t;

  // mirror of the neighbor table plus the queue of reports still owed by the block
  class link_table_tracker;
    bit           slot_used[TABLE_ENTRIES];
    addr_t        slot_addr[TABLE_ENTRIES];
    str_t         slot_strength[TABLE_ENTRIES];
    int           fill_count;
    str_t         last_best;
    link_report_t pending_reports[$];
    int           error_count;
    int           n_updated;
    int           n_added;
    int           n_dropped;
    int           n_checked;

    // apply one broadcast to the mirrored table and work out the report
    function link_report_t predict_report(addr_t addr, str_t strength);
      link_report_t rep;
      bit           found;
      found       = 1'b0;
      rep.outcome = OUTCOME_DROPPED;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!found && slot_used[i] && slot_addr[i] == addr) begin
          slot_strength[i] = strength;
          rep.outcome      = OUTCOME_UPDATED;
          found            = 1'b1;
        end
      end
      if (!found && fill_count < TABLE_ENTRIES) begin
        slot_used[fill_count]     = 1'b1;
        slot_addr[fill_count]     = addr;
        slot_strength[fill_count] = strength;
        fill_count++;
        rep.outcome = OUTCOME_ADDED;
      end
      // best scan in slot order, ties move to the later slot
      rep.best_valid    = 1'b0;
      rep.best_addr     = '0;
      rep.best_strength = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i] && (!rep.best_valid || slot_strength[i] >= rep.best_strength)) begin
          rep.best_valid    = 1'b1;
          rep.best_addr     = slot_addr[i];
          rep.best_strength = slot_strength[i];
        end
      end
      return rep;
    endfunction

    function void note_broadcast(addr_t addr, str_t strength);
      link_report_t rep;
      rep = predict_report(addr, strength);
      case (rep.outcome)
        OUTCOME_UPDATED: n_updated++;
        OUTCOME_ADDED:   n_added++;
        default:         n_dropped++;
      endcase
      last_best = rep.best_strength;
      pending_reports.push_back(rep);
    endfunction

    function void check_report(logic [OUTCOME_W-1:0] outcome, logic best_valid,
                               addr_t best_addr, str_t best_strength);
      link_report_t want;
      if (pending_reports.size() == 0) begin
        $error("result transaction with no expectation waiting");
        error_count++;
        return;
      end
      want = pending_reports.pop_front();
      n_checked++;
      if (outcome !== want.outcome) begin
        $error("outcome mismatch: expected %0d, got %0d", want.outcome, outcome);
        error_count++;
      end
      if (best_valid !== want.best_valid) begin
        $error("best_valid mismatch: expected %0d, got %0d", want.best_valid, best_valid);
        error_count++;
      end
      if (best_addr !== want.best_addr) begin
        $error("best_addr mismatch: expected %h, got %h", want.best_addr, best_addr);
        error_count++;
      end
      if (best_strength !== want.best_strength) begin
        $error("best_strength mismatch: expected %h, got %h", want.best_strength,
               best_strength);
        error_count++;
      end
    endfunction
  endclass

  localparam int RANDOM_PER_PHASE = 420;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int DIRECTED_COUNT   = 22;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  addr_t                sender_addr = '0;
  str_t                 signal_strength = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUTCOME_W-1:0] outcome;
  logic                 best_valid;
  addr_t                best_addr;
  str_t                 best_strength;

  link_table_tracker tracker = new;

  // idling knobs, set per phase by the stimulus
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  // long receiver hold-off request, counted down by the receiver process
  int long_hold    = 0;

  // directed part: extremes of both fields, ties, updates, fill to the last
  // slot, then new senders against a full table
  addr_t dir_addr[DIRECTED_COUNT] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000,
    16'h7FFF, 16'hFFFE, 16'h1234, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h0080,
    16'hC3C3, 16'h3C3C, 16'hBEEF, 16'h0000, 16'h3C3C, 16'h0002
  };
  str_t dir_str[DIRECTED_COUNT] = '{
    16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h0001, 16'h8000,
    16'h7FFF, 16'hFFFE, 16'h1234, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h0080,
    16'hC3C3, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF
  };

  always #5 clk = ~clk;

  neighbor_table_best_rssi i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sender_addr    (sender_addr),
    .signal_strength(signal_strength),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .best_valid     (best_valid),
    .best_addr      (best_addr),
    .best_strength  (best_strength)
  );

  // offer one broadcast and return at the edge where it is accepted;
  // valid stays high so back-to-back transactions need no second assignment
  task automatic send_broadcast(addr_t addr, str_t strength);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    sender_addr     <= addr;
    signal_strength <= strength;
    do @(posedge clk); while (in_stall);
    tracker.note_broadcast(addr, strength);
  endtask

  // mostly known neighbors with fresh strengths, some unknown senders
  task automatic send_random_broadcast();
    addr_t addr;
    str_t  strength;
    int    roll;
    roll = $urandom_range(99);
    if (roll < 80 && tracker.fill_count > 0)
      addr = tracker.slot_addr[$urandom_range(tracker.fill_count - 1)];
    else
      addr = addr_t'($urandom_range(16'hFFFF));
    roll = $urandom_range(99);
    if (roll < 10)
      strength = tracker.last_best;  // forces a tie with the current best
    else if (roll < 15)
      strength = '0;
    else if (roll < 20)
      strength = '1;
    else
      strength = str_t'($urandom_range(16'hFFFF));
    send_broadcast(addr, strength);
  endtask

  // sender goes quiet until every owed report has come back
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
  endtask

  // receiver: sample at the rising edge, decide the stall at the falling edge
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        tracker.check_report(outcome, best_valid, best_addr, best_strength);
      @(negedge clk);
      if (long_hold > 0) begin
        out_stall <= 1'b1;
        long_hold--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // stimulus: directed items, then four idling phases of random traffic
  initial begin
    int phase_tx[4];
    int phase_rx[4];
    phase_tx = '{0, 49, 0, 25};
    phase_rx = '{0, 0, 49, 25};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIRECTED_COUNT; k++)
      send_broadcast(dir_addr[k], dir_str[k]);
    wait_for_drain();

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = phase_tx[p];
      rx_stall_pct = phase_rx[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long hold-off while the sender keeps offering: the block backs up
        if (p == 0 && n == RANDOM_PER_PHASE / 2)
          long_hold = LONG_HOLD_CYCLES;
        send_random_broadcast();
      end
      wait_for_drain();
    end

    // let any stray result show up before the verdict
    repeat (TABLE_ENTRIES + 16) @(posedge clk);

    $display("run covered %0d broadcasts: %0d new neighbors, %0d strength updates, %0d dropped",
             tracker.n_added + tracker.n_updated + tracker.n_dropped, tracker.n_added,
             tracker.n_updated, tracker.n_dropped);
    $display("%0d reports checked over four idling phases, one %0d-cycle receiver hold-off",
             tracker.n_checked, LONG_HOLD_CYCLES);
    if (tracker.error_count == 0 && tracker.pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
